// ----- design/itt_pkg.sv -----
// Shared types and constants of the interval timer table.
package itt_pkg;

  // table geometry
  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int SCAN_W      = $clog2(TIMER_SLOTS + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 16;
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;

  // most negative repeat count, where a firing saturates
  localparam logic [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_CREATE     = 2'd0,
    OP_CANCEL     = 2'd1,
    OP_CANCEL_ALL = 2'd2,
    OP_TICK       = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_FIRED   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } back_state_t;

  // one decoded input word
  typedef struct packed {
    op_t                        op;
    logic [PERIOD_W-1:0]        period;
    logic signed [COUNT_W-1:0]  count;
    logic [ID_W-1:0]            target;
    logic [TIME_W-1:0]          now;
  } cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

  // one table entry in slot memory
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   last;
    logic [COUNT_W-1:0]  remaining;
    logic [ID_W-1:0]     id;
  } slot_t;

  localparam int SLOT_DW = $bits(slot_t);

endpackage

// ----- design/itt_ifs.sv -----
// Valid/ready channel interfaces for input words and result words.
interface itt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [itt_pkg::OP_W-1:0]              operation;
  logic [itt_pkg::PERIOD_W-1:0]          period_seconds;
  logic signed [itt_pkg::COUNT_W-1:0]    repeat_count;
  logic [itt_pkg::ID_W-1:0]              target_id;
  logic [itt_pkg::TIME_W-1:0]            now_time;

  modport source (output valid, operation, period_seconds, repeat_count, target_id,
                  now_time, input ready);
  modport sink   (input valid, operation, period_seconds, repeat_count, target_id,
                  now_time, output ready);
endinterface

interface itt_out_if;
  logic                        valid;
  logic                        ready;
  logic [itt_pkg::KIND_W-1:0]  result_kind;
  logic [itt_pkg::ID_W-1:0]    timer_id;
  logic                        last_of_run;

  modport source (output valid, result_kind, timer_id, last_of_run, input ready);
  modport sink   (input valid, result_kind, timer_id, last_of_run, output ready);
endinterface

// ----- design/itt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module itt_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                       wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                       rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, holds its data while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/itt_front.sv -----
// Front end: accepts input words, decodes them and queues the commands.
module itt_front (
  input  logic                clk,
  input  logic                rst_n,
  itt_in_if.sink              in_chan,
  output itt_pkg::cmdq_head_t head,
  input  logic                pop
);

  itt_pkg::cmd_t                   q_r [itt_pkg::CMDQ_DEPTH];
  itt_pkg::cmd_t                   in_cmd;
  logic [itt_pkg::CMDQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [itt_pkg::CMDQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [itt_pkg::CMDQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            push;
  logic                            do_pop;

  // decode the word into a command
  always_comb begin
    in_cmd.op     = itt_pkg::op_t'(in_chan.operation);
    in_cmd.period = in_chan.period_seconds;
    in_cmd.count  = in_chan.repeat_count;
    in_cmd.target = in_chan.target_id;
    in_cmd.now    = in_chan.now_time;
  end

  assign in_chan.ready = (cnt_r != itt_pkg::CMDQ_CNT_W'(itt_pkg::CMDQ_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign do_pop        = pop && (cnt_r != '0);

  // pointers and fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == itt_pkg::CMDQ_PTR_W'(itt_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == itt_pkg::CMDQ_PTR_W'(itt_pkg::CMDQ_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

// ----- design/itt_back.sv -----
// Back end: slot table, create/cancel handling and the tick/cancel slot scan.
module itt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  itt_pkg::cmdq_head_t head,
  output logic                pop,
  itt_out_if.source           out_chan
);

  itt_pkg::back_state_t            state_r, state_nxt;
  logic [itt_pkg::TIMER_SLOTS-1:0] valid_r, valid_nxt;
  logic [itt_pkg::ID_W-1:0]        id_cnt_r, id_cnt_nxt;
  itt_pkg::cmd_t                   cur_r;
  logic [itt_pkg::SCAN_W-1:0]      scan_idx_r;
  logic                            ev_v_r;
  logic [itt_pkg::SLOT_W-1:0]      ev_idx_r;
  logic                            found_r;
  logic [itt_pkg::NRES_W-1:0]      n_r;
  logic                            pend_v_r;
  logic [itt_pkg::ID_W-1:0]        pend_id_r;

  logic                            out_v_r, out_v_nxt;
  itt_pkg::kind_t                  out_kind_r, out_kind_nxt;
  logic [itt_pkg::ID_W-1:0]        out_id_r, out_id_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_load;
  logic                            out_free;

  logic                            free_any;
  logic [itt_pkg::SLOT_W-1:0]      free_idx;
  logic                            start_scan;
  logic                            create_do;
  logic                            scan_end;

  itt_pkg::slot_t                  rd_slot;
  itt_pkg::slot_t                  wr_slot;
  logic                            ram_we, ram_re;
  logic [itt_pkg::SLOT_W-1:0]      ram_waddr;
  logic                            is_tick, is_cancel;
  logic                            ev_slot_valid;
  logic [itt_pkg::TIME_W:0]        due;
  logic                            fire, report, need_out, stall, advance, issue;
  logic [itt_pkg::COUNT_W-1:0]     rem_new;
  logic                            tick_free, cancel_hit;

  assign out_free = !out_v_r || out_chan.ready;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = itt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = itt_pkg::SLOT_W'(i);
      end
    end
  end

  // slot memory
  itt_ram #(
    .DATA_W (itt_pkg::SLOT_DW),
    .DEPTH  (itt_pkg::TIMER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_slot),
    .re    (ram_re),
    .raddr (scan_idx_r[itt_pkg::SLOT_W-1:0]),
    .rdata (rd_slot)
  );

  // evaluation of the slot whose data the memory just returned
  always_comb begin
    is_tick       = (cur_r.op == itt_pkg::OP_TICK);
    is_cancel     = (cur_r.op == itt_pkg::OP_CANCEL);
    ev_slot_valid = valid_r[ev_idx_r];
    due           = {1'b0, rd_slot.last} +
                    {{(itt_pkg::TIME_W + 1 - itt_pkg::PERIOD_W){1'b0}}, rd_slot.period};
    fire          = (state_r == itt_pkg::B_SCAN) && ev_v_r && is_tick && ev_slot_valid &&
                    (due <= {1'b0, cur_r.now});
    if (fire && (rd_slot.remaining != itt_pkg::COUNT_MIN)) begin
      rem_new = rd_slot.remaining - {{(itt_pkg::COUNT_W-1){1'b0}}, 1'b1};
    end else begin
      rem_new = rd_slot.remaining;
    end
    tick_free  = (state_r == itt_pkg::B_SCAN) && ev_v_r && is_tick && ev_slot_valid &&
                 (rem_new == '0);
    cancel_hit = (state_r == itt_pkg::B_SCAN) && ev_v_r && is_cancel && ev_slot_valid &&
                 (rd_slot.id == cur_r.target) && !found_r;
    report     = fire && (n_r < itt_pkg::NRES_W'(itt_pkg::MAX_RESULTS));
    // a new report pushes the held one out, so the output must have room
    need_out   = report && pend_v_r;
    stall      = need_out && !out_free;
    advance    = !stall;
    issue      = (state_r == itt_pkg::B_SCAN) &&
                 (scan_idx_r < itt_pkg::SCAN_W'(itt_pkg::TIMER_SLOTS)) && advance;
    scan_end   = (scan_idx_r == itt_pkg::SCAN_W'(itt_pkg::TIMER_SLOTS)) && !ev_v_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itt_pkg::B_IDLE: begin
        if (head.valid && ((head.cmd.op == itt_pkg::OP_CANCEL) ||
                           (head.cmd.op == itt_pkg::OP_TICK))) begin
          state_nxt = itt_pkg::B_SCAN;
        end
      end
      itt_pkg::B_SCAN: begin
        if (scan_end) begin
          state_nxt = pend_v_r ? itt_pkg::B_FLUSH : itt_pkg::B_IDLE;
        end
      end
      itt_pkg::B_FLUSH: begin
        if (out_free) begin
          state_nxt = itt_pkg::B_IDLE;
        end
      end
      default: state_nxt = itt_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop          = 1'b0;
    start_scan   = 1'b0;
    create_do    = 1'b0;
    out_load     = 1'b0;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    valid_nxt    = valid_r;
    id_cnt_nxt   = id_cnt_r;
    case (state_r)
      itt_pkg::B_IDLE: begin
        if (head.valid) begin
          case (head.cmd.op)
            itt_pkg::OP_CREATE: begin
              if (out_free) begin
                pop          = 1'b1;
                out_load     = 1'b1;
                out_last_nxt = 1'b1;
                if (free_any) begin
                  create_do           = 1'b1;
                  valid_nxt[free_idx] = 1'b1;
                  out_kind_nxt        = itt_pkg::KIND_CREATED;
                  out_id_nxt          = id_cnt_r;
                  id_cnt_nxt          = id_cnt_r + 1'b1;
                end else begin
                  out_kind_nxt = itt_pkg::KIND_FULL;
                  out_id_nxt   = '0;
                end
              end
            end
            itt_pkg::OP_CANCEL_ALL: begin
              pop       = 1'b1;
              valid_nxt = '0;
            end
            default: begin
              pop        = 1'b1;
              start_scan = 1'b1;
            end
          endcase
        end
      end
      itt_pkg::B_SCAN: begin
        if (need_out) begin
          out_load     = out_free;
          out_kind_nxt = itt_pkg::KIND_FIRED;
          out_id_nxt   = pend_id_r;
          out_last_nxt = 1'b0;
        end
        if (advance && (tick_free || cancel_hit)) begin
          valid_nxt[ev_idx_r] = 1'b0;
        end
      end
      itt_pkg::B_FLUSH: begin
        out_load     = out_free;
        out_kind_nxt = itt_pkg::KIND_FIRED;
        out_id_nxt   = pend_id_r;
        out_last_nxt = 1'b1;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
    out_v_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);
  end

  // memory write: new timer on create, updated entry on a firing
  always_comb begin
    ram_re = issue;
    if (create_do) begin
      ram_we            = 1'b1;
      ram_waddr         = free_idx;
      wr_slot.period    = head.cmd.period;
      wr_slot.last      = head.cmd.now;
      wr_slot.remaining = head.cmd.count;
      wr_slot.id        = id_cnt_r;
    end else begin
      ram_we            = fire && advance;
      ram_waddr         = ev_idx_r;
      wr_slot.period    = rd_slot.period;
      wr_slot.last      = cur_r.now;
      wr_slot.remaining = rem_new;
      wr_slot.id        = rd_slot.id;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= itt_pkg::B_IDLE;
      valid_r  <= '0;
      id_cnt_r <= '0;
      out_v_r  <= 1'b0;
      ev_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      found_r  <= 1'b0;
      n_r      <= '0;
      scan_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      valid_r  <= valid_nxt;
      id_cnt_r <= id_cnt_nxt;
      out_v_r  <= out_v_nxt;
      if (start_scan) begin
        scan_idx_r <= '0;
        ev_v_r     <= 1'b0;
        found_r    <= 1'b0;
        n_r        <= '0;
        pend_v_r   <= 1'b0;
      end else if (state_r == itt_pkg::B_SCAN) begin
        if (advance) begin
          ev_v_r <= issue;
          if (issue) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
          if (cancel_hit) begin
            found_r <= 1'b1;
          end
          if (report) begin
            pend_v_r <= 1'b1;
            n_r      <= n_r + 1'b1;
          end
        end
      end else if ((state_r == itt_pkg::B_FLUSH) && out_free) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_scan) begin
      cur_r <= head.cmd;
    end
    if (issue) begin
      ev_idx_r <= scan_idx_r[itt_pkg::SLOT_W-1:0];
    end
    if ((state_r == itt_pkg::B_SCAN) && advance && report) begin
      pend_id_r <= rd_slot.id;
    end
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_id_r   <= out_id_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.timer_id    = out_id_r;
  assign out_chan.last_of_run = out_last_r;

  // checks
  a_ev_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != itt_pkg::B_SCAN) |-> !ev_v_r)
    else $error("slot evaluation outside a scan");

  a_report_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= itt_pkg::NRES_W'(itt_pkg::MAX_RESULTS))
    else $error("more reports than the result limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_v_r || out_chan.ready))
    else $error("output word overwritten before it was taken");

  a_flush_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == itt_pkg::B_FLUSH) |-> pend_v_r)
    else $error("flush state without a held firing");

  a_pop_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == itt_pkg::B_IDLE))
    else $error("command popped while busy");

endmodule

// ----- design/interval_timer_table_core.sv -----
// Top level of the interval timer table: front end, command queue and back end.
//
// Usage:
//   in_chan carries command words (create, cancel by id, cancel all, tick);
//   a word is taken when valid and ready are both high. out_chan carries
//   result words: created id, table full, or fired id; last_of_run marks the
//   final word of a command. Cancel, cancel all and a tick with nothing due
//   give no word.
//   Commands pass through a two-entry queue, so input keeps flowing while the
//   back end works. Create and cancel all need no scan; a create result word
//   passes from the queue head into the output register. Cancel and tick scan
//   the slot memory one slot per cycle through its single read port, while
//   the output is not stalled. Reset clears all slot valid bits and the id
//   counter; no clearing pass is needed. When the receiver stalls, the output
//   register holds its word and the scan waits on the next firing; the input
//   side fills the queue and then drops ready.
module interval_timer_table_core (
  input  logic       clk,
  input  logic       rst_n,
  itt_in_if.sink     in_chan,
  itt_out_if.source  out_chan
);

  itt_pkg::cmdq_head_t head;
  logic                pop;

  itt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head    (head),
    .pop     (pop)
  );

  itt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// ----- tb/tb_interval_timer_table_core.sv -----
// Self-checking testbench for the interval timer table core.
`timescale 1ns / 1ps

module tb_interval_timer_table_core;

  localparam int LIMIT_CYCLES = 200_000;
  localparam int TAIL_CYCLES  = 2 * itt_pkg::TIMER_SLOTS + 8;

  // one result word as the table reports it
  typedef struct packed {
    itt_pkg::kind_t           kind;
    logic [itt_pkg::ID_W-1:0] id;
    logic                     last;
  } timer_report_t;

  logic clk = 1'b0;
  logic rst_n;

  itt_in_if  in_chan ();
  itt_out_if out_chan ();

  interval_timer_table_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // shadow copy of the timer table
  logic                         tbl_valid  [itt_pkg::TIMER_SLOTS];
  logic [itt_pkg::PERIOD_W-1:0] tbl_period [itt_pkg::TIMER_SLOTS];
  logic [itt_pkg::TIME_W-1:0]   tbl_last   [itt_pkg::TIMER_SLOTS];
  logic [itt_pkg::COUNT_W-1:0]  tbl_left   [itt_pkg::TIMER_SLOTS];
  logic [itt_pkg::ID_W-1:0]     tbl_id     [itt_pkg::TIMER_SLOTS];
  logic [itt_pkg::ID_W-1:0]     next_id;

  timer_report_t timer_reports[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int n_errors      = 0;
  int cycle_count   = 0;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // apply one accepted word to the shadow table and queue the words it reports
  task automatic step_timer_table(input itt_pkg::op_t op,
                                  input logic [itt_pkg::PERIOD_W-1:0] period,
                                  input logic [itt_pkg::COUNT_W-1:0] count,
                                  input logic [itt_pkg::ID_W-1:0] target,
                                  input logic [itt_pkg::TIME_W-1:0] now);
    timer_report_t               run[$];
    timer_report_t               rep;
    int                          slot;
    logic [itt_pkg::TIME_W:0]    due;
    slot = -1;
    case (op)
      itt_pkg::OP_CREATE: begin
        for (int s = 0; s < itt_pkg::TIMER_SLOTS; s++)
          if (!tbl_valid[s] && slot < 0) slot = s;
        if (slot >= 0) begin
          tbl_valid[slot]  = 1'b1;
          tbl_period[slot] = period;
          tbl_left[slot]   = count;
          tbl_last[slot]   = now;
          tbl_id[slot]     = next_id;
          rep = '{itt_pkg::KIND_CREATED, next_id, 1'b0};
          run = {run, rep};
          next_id = next_id + 1'b1;
        end else begin
          rep = '{itt_pkg::KIND_FULL, '0, 1'b0};
          run = {run, rep};
        end
      end
      itt_pkg::OP_CANCEL: begin
        // lowest matching slot only
        for (int s = 0; s < itt_pkg::TIMER_SLOTS; s++)
          if (tbl_valid[s] && tbl_id[s] == target && slot < 0) slot = s;
        if (slot >= 0) tbl_valid[slot] = 1'b0;
      end
      itt_pkg::OP_CANCEL_ALL: begin
        foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
      end
      default: begin
        // tick: expiry sum kept one bit wider so it never wraps
        for (int s = 0; s < itt_pkg::TIMER_SLOTS; s++) begin
          if (tbl_valid[s]) begin
            due = {1'b0, tbl_last[s]} +
                  {{(itt_pkg::TIME_W+1-itt_pkg::PERIOD_W){1'b0}}, tbl_period[s]};
            if (due <= {1'b0, now}) begin
              if (run.size() < itt_pkg::MAX_RESULTS) begin
                rep = '{itt_pkg::KIND_FIRED, tbl_id[s], 1'b0};
                run = {run, rep};
              end
              tbl_last[s] = now;
              if (tbl_left[s] != itt_pkg::COUNT_MIN) tbl_left[s] = tbl_left[s] - 1'b1;
            end
            if (tbl_left[s] == '0) tbl_valid[s] = 1'b0;
          end
        end
      end
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[k]) timer_reports = {timer_reports, run[k]};
  endtask

  // offer one word; returns at the rising edge that takes it
  task automatic send_word(input itt_pkg::op_t op,
                           input logic [itt_pkg::PERIOD_W-1:0] period,
                           input logic [itt_pkg::COUNT_W-1:0] count,
                           input logic [itt_pkg::ID_W-1:0] target,
                           input logic [itt_pkg::TIME_W-1:0] now);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.operation      <= op;
    in_chan.period_seconds <= period;
    in_chan.repeat_count   <= count;
    in_chan.target_id      <= target;
    in_chan.now_time       <= now;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    step_timer_table(op, period, count, target, now);
  endtask

  // receiver: random stalls, or a counted hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // compare each taken result word with the oldest queued one
  always @(posedge clk) begin : check_results
    timer_report_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (timer_reports.size() == 0) begin
        $error("unexpected result word: result_kind %0d timer_id %0d",
               out_chan.result_kind, out_chan.timer_id);
        n_errors++;
      end else begin
        want = timer_reports.pop_front();
        if (out_chan.result_kind !== want.kind) begin
          $error("result_kind: expected %0d, got %0d", want.kind, out_chan.result_kind);
          n_errors++;
        end
        if (out_chan.timer_id !== want.id) begin
          $error("timer_id: expected %0d, got %0d", want.id, out_chan.timer_id);
          n_errors++;
        end
        if (out_chan.last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, out_chan.last_of_run);
          n_errors++;
        end
      end
    end
  end

  // empty table: nothing reported
  task automatic test_empty_table();
    send_word(itt_pkg::OP_CANCEL_ALL, '0, '0, '0, '0);
    send_word(itt_pkg::OP_TICK, '1, '1, '1, '0);
    send_word(itt_pkg::OP_CANCEL, '0, '0, 16'hFFFF, '1);
  endtask

  // field extremes, zero and minimum counts, wide expiry sum, cancel cases
  task automatic test_create_and_tick();
    logic [itt_pkg::ID_W-1:0] base;
    base = next_id;
    send_word(itt_pkg::OP_CREATE, 16'd0,    16'sd1,             '0, 32'd0);
    send_word(itt_pkg::OP_CREATE, 16'hFFFF, itt_pkg::COUNT_MIN, '1, 32'hFFFF_FFFF);
    send_word(itt_pkg::OP_CREATE, 16'd0,    16'sd0,             '0, 32'd0);
    send_word(itt_pkg::OP_CREATE, 16'd10,   16'sd0,             '0, 32'd0);
    send_word(itt_pkg::OP_CREATE, 16'd1,    itt_pkg::COUNT_MIN, '0, 32'd0);
    send_word(itt_pkg::OP_CREATE, 16'd3,    16'sh7FFF,          '0, 32'd0);
    send_word(itt_pkg::OP_TICK,   '0, '0, '0, 32'd0);
    send_word(itt_pkg::OP_TICK,   '0, '0, '0, 32'd5);
    send_word(itt_pkg::OP_CANCEL, '0, '0, base + 16'd999, '0);
    send_word(itt_pkg::OP_CANCEL, '0, '0, base + 16'd2, '0);
    send_word(itt_pkg::OP_TICK,   '0, '0, '0, 32'hFFFF_FFFF);
    send_word(itt_pkg::OP_CANCEL_ALL, '0, '0, '0, '0);
  endtask

  // long receiver hold-off while the table fills, overflows and fires
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 300;
    send_word(itt_pkg::OP_CANCEL_ALL, '0, '0, '0, '0);
    for (int k = 0; k < itt_pkg::TIMER_SLOTS + 2; k++)
      send_word(itt_pkg::OP_CREATE, itt_pkg::PERIOD_W'(k), 16'sd1, '0, 32'd1000);
    send_word(itt_pkg::OP_TICK, '0, '0, '0, 32'd2000);
    send_word(itt_pkg::OP_CANCEL_ALL, '0, '0, '0, '0);
  endtask

  // mostly well-formed traffic with a rising now_time, with some raw noise
  task automatic test_random_phase(input int n_words, input int sender_idle,
                                   input int receiver_idle);
    int                           sel;
    int                           live[$];
    logic [itt_pkg::TIME_W-1:0]   cur_now;
    logic [itt_pkg::PERIOD_W-1:0] period;
    logic [itt_pkg::COUNT_W-1:0]  count;
    logic [itt_pkg::ID_W-1:0]     target;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    cur_now = $urandom();
    for (int n = 0; n < n_words; n++) begin
      sel    = $urandom_range(99);
      period = ($urandom_range(7) == 0) ? itt_pkg::PERIOD_W'($urandom()) :
                                          itt_pkg::PERIOD_W'($urandom_range(60));
      case ($urandom_range(9))
        0:       count = itt_pkg::COUNT_W'($urandom());
        1:       count = '0;
        2:       count = itt_pkg::COUNT_MIN;
        3:       count = '1;
        default: count = itt_pkg::COUNT_W'($urandom_range(6, 1));
      endcase
      target = itt_pkg::ID_W'($urandom());
      if (sel < 12) begin
        send_word(itt_pkg::op_t'($urandom_range(3)), itt_pkg::PERIOD_W'($urandom()),
                  itt_pkg::COUNT_W'($urandom()), target, itt_pkg::TIME_W'($urandom()));
      end else if (sel < 45) begin
        send_word(itt_pkg::OP_CREATE, period, count, target, cur_now);
      end else if (sel < 80) begin
        cur_now = cur_now + itt_pkg::TIME_W'($urandom_range(40));
        send_word(itt_pkg::OP_TICK, itt_pkg::PERIOD_W'($urandom()),
                  itt_pkg::COUNT_W'($urandom()), target, cur_now);
      end else if (sel < 95) begin
        live.delete();
        foreach (tbl_valid[s]) if (tbl_valid[s]) live = {live, s};
        if (live.size() > 0 && $urandom_range(3) != 0)
          target = tbl_id[live[$urandom_range(live.size() - 1)]];
        send_word(itt_pkg::OP_CANCEL, period, count, target, itt_pkg::TIME_W'($urandom()));
      end else begin
        send_word(itt_pkg::OP_CANCEL_ALL, period, count, target,
                  itt_pkg::TIME_W'($urandom()));
      end
    end
  endtask

  // stop offering, let every queued word arrive, then give the block time to settle
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (timer_reports.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.operation      = itt_pkg::OP_CREATE;
    in_chan.period_seconds = '0;
    in_chan.repeat_count   = '0;
    in_chan.target_id      = '0;
    in_chan.now_time       = '0;
    foreach (tbl_valid[s]) tbl_valid[s] = 1'b0;
    next_id = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 27;
    recv_idle_pct = 67;
    test_empty_table();
    test_create_and_tick();
    test_backpressure();
    test_random_phase(40, 27, 67);
    test_random_phase(40, 67, 27);
    test_random_phase(40, 0, 0);
    drain_results();

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- interval_timer_table_core.f -----
design/itt_pkg.sv
design/itt_ifs.sv
design/itt_ram.sv
design/itt_front.sv
design/itt_back.sv
design/interval_timer_table_core.sv
tb/tb_interval_timer_table_core.sv
